// ----- sv/trht_pkg.sv -----
package trht_pkg;

  // Sizing
  localparam int MAX_REGIONS = 32;
  localparam int COORD_BITS  = 10;
  localparam int PAGE_BITS   = 4;

  localparam int IDX_W   = $clog2(MAX_REGIONS);
  localparam int CNT_W   = $clog2(MAX_REGIONS + 1);
  localparam int FIELD_W = 11;
  localparam int CPAGE_W = 4;
  localparam int ID_W    = 8;
  localparam int MIN_W   = 10;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [31:0] COORD_MAX = 32'((64'd1 << COORD_BITS) - 64'd1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_PAGE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE     = CFG_IDX_W'(1);

  // Item kinds, gestures and touch modes
  localparam logic [1:0] KIND_DEFINE  = 2'd0;
  localparam logic [1:0] KIND_TOUCH   = 2'd1;
  localparam logic [1:0] KIND_GESTURE = 2'd2;
  localparam logic [1:0] GEST_DOUBLE  = 2'd0;
  localparam logic [1:0] GEST_LONG    = 2'd1;
  localparam logic [1:0] MODE_CLICK   = 2'd0;
  localparam logic [1:0] MODE_DOUBLE  = 2'd1;
  localparam logic [1:0] MODE_LONG    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_LOAD
  } trht_state_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] left;
    logic [COORD_BITS-1:0] right;
    logic [COORD_BITS-1:0] lower;
    logic [COORD_BITS-1:0] top;
    logic [PAGE_BITS-1:0]  page;
    logic [ID_W-1:0]       id;
  } trht_region_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [FIELD_W-1:0] x_first;
    logic [FIELD_W-1:0] y_first;
    logic [FIELD_W-1:0] x_second;
    logic [FIELD_W-1:0] y_second;
    logic [CPAGE_W-1:0] region_page;
    logic [ID_W-1:0]    element_id;
    logic               pressed;
    logic [1:0]         gesture;
  } trht_item_t;

  typedef struct packed {
    logic capture;
    logic finish_plain;
    logic scan_start;
    logic scan_step;
    logic scan_done;
    logic load_out;
  } trht_cmd_t;

  typedef struct packed {
    logic do_scan;
    logic count_zero;
    logic scan_hit;
    logic scan_end;
    logic out_free;
  } trht_sts_t;

  // Corner lies in 0 .. 2^COORD_BITS-1
  function automatic logic coord_ok(logic [FIELD_W-1:0] c);
    logic [31:0] w;
    w = {{(32-FIELD_W){1'b0}}, c};
    return !c[FIELD_W-1] && (w <= COORD_MAX);
  endfunction

  function automatic logic [COORD_BITS-1:0] to_coord(logic [FIELD_W-1:0] c);
    logic [31:0] w;
    w = {{(32-FIELD_W){1'b0}}, c};
    return w[COORD_BITS-1:0];
  endfunction

  function automatic logic [PAGE_BITS-1:0] to_page(logic [CPAGE_W-1:0] p);
    logic [31:0] w;
    w = {{(32-CPAGE_W){1'b0}}, p};
    return w[PAGE_BITS-1:0];
  endfunction

  // Absolute difference of two signed fields
  function automatic logic [FIELD_W:0] abs_diff(logic [FIELD_W-1:0] a,
                                                logic [FIELD_W-1:0] b);
    logic signed [FIELD_W:0] d;
    d = $signed({a[FIELD_W-1], a}) - $signed({b[FIELD_W-1], b});
    return d[FIELD_W] ? (FIELD_W+1)'(-d) : (FIELD_W+1)'(d);
  endfunction

endpackage

// ----- sv/trht_in_if.sv -----
interface trht_in_if import trht_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [FIELD_W-1:0] x_first;
  logic [FIELD_W-1:0] y_first;
  logic [FIELD_W-1:0] x_second;
  logic [FIELD_W-1:0] y_second;
  logic [CPAGE_W-1:0] region_page;
  logic [ID_W-1:0]    element_id;
  logic               pressed;
  logic [1:0]         gesture;

  modport source (
    output valid, kind, x_first, y_first, x_second, y_second, region_page,
           element_id, pressed, gesture,
    input  ready
  );
  modport sink (
    input  valid, kind, x_first, y_first, x_second, y_second, region_page,
           element_id, pressed, gesture,
    output ready
  );
endinterface

// ----- sv/trht_out_if.sv -----
interface trht_out_if import trht_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               hit;
  logic [ID_W-1:0]    hit_id;
  logic [1:0]         touch_mode;
  logic [CPAGE_W-1:0] hit_page;
  logic               define_ok;

  modport source (
    output valid, hit, hit_id, touch_mode, hit_page, define_ok,
    input  ready
  );
  modport sink (
    input  valid, hit, hit_id, touch_mode, hit_page, define_ok,
    output ready
  );
endinterface

// ----- sv/trht_cfg_if.sv -----
interface trht_cfg_if import trht_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/touch_region_hit_test_unit.sv -----
// Flow: a define, a non-scanning event or a scan with no stored regions goes from
// DECODE straight to LOAD; a scan reads one table entry a cycle and stops at the first
// hitting entry or after the last stored region, then goes to LOAD, which waits for a free output register.
// One item in flight at a time: no new item is accepted until its result is loaded.
// Reset: asynchronous, active low; clears the region count, the controller and the
// output valid, and sets current_page to 0 and min_element_size to 5.
module touch_region_hit_test_unit import trht_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  trht_in_if.sink    in_if,
  trht_out_if.source out_if,
  trht_cfg_if.sink   cfg_if
);

  trht_item_t item;
  trht_cmd_t  cmd;
  trht_sts_t  sts;

  assign cfg_if.ready = 1'b1;

  // Pack the input payload
  assign item.kind        = in_if.kind;
  assign item.x_first     = in_if.x_first;
  assign item.y_first     = in_if.y_first;
  assign item.x_second    = in_if.x_second;
  assign item.y_second    = in_if.y_second;
  assign item.region_page = in_if.region_page;
  assign item.element_id  = in_if.element_id;
  assign item.pressed     = in_if.pressed;
  assign item.gesture     = in_if.gesture;

  trht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  trht_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .cfg_valid_i  (cfg_if.valid),
    .cfg_index_i  (cfg_if.index),
    .cfg_data_i   (cfg_if.data),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (out_if.ready),
    .out_valid_o  (out_if.valid),
    .hit_o        (out_if.hit),
    .hit_id_o     (out_if.hit_id),
    .touch_mode_o (out_if.touch_mode),
    .hit_page_o   (out_if.hit_page),
    .define_ok_o  (out_if.define_ok)
  );

endmodule

// ----- sv/trht_ctrl.sv -----
module trht_ctrl import trht_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  trht_sts_t sts_i,
  output trht_cmd_t cmd_o
);

  trht_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (sts_i.do_scan && !sts_i.count_zero) state_d = ST_SCAN;
        else state_d = ST_LOAD;
      end
      ST_SCAN: begin
        if (sts_i.scan_hit || sts_i.scan_end) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_DECODE: begin
        if (sts_i.do_scan && !sts_i.count_zero) cmd_o.scan_start = 1'b1;
        else cmd_o.finish_plain = 1'b1;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.scan_done = sts_i.scan_hit || sts_i.scan_end;
      end
      ST_LOAD: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ----- sv/trht_datapath.sv -----
module trht_datapath import trht_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  trht_item_t            item_i,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  trht_cmd_t             cmd_i,
  output trht_sts_t             sts_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic                  hit_o,
  output logic [ID_W-1:0]       hit_id_o,
  output logic [1:0]            touch_mode_o,
  output logic [CPAGE_W-1:0]    hit_page_o,
  output logic                  define_ok_o
);

  trht_item_t          item_q;
  logic [CPAGE_W-1:0]  cur_page_q;
  logic [MIN_W-1:0]    min_size_q;
  logic [CNT_W-1:0]    count_q;
  logic [CNT_W-1:0]    scan_idx_q;
  logic [CNT_W-1:0]    cmp_idx_q;
  logic                pend_q;
  trht_region_t        rd_data_q;
  trht_region_t        mem_q [MAX_REGIONS];

  logic                res_hit_q;
  logic [ID_W-1:0]     res_id_q;
  logic [1:0]          res_mode_q;
  logic [CPAGE_W-1:0]  res_page_q;
  logic                res_ok_q;

  logic                out_valid_q;
  logic                out_hit_q;
  logic [ID_W-1:0]     out_id_q;
  logic [1:0]          out_mode_q;
  logic [CPAGE_W-1:0]  out_page_q;
  logic                out_ok_q;

  logic                do_scan;
  logic [1:0]          scan_mode;
  logic                define_ok;
  logic [FIELD_W:0]    span_x;
  logic [FIELD_W:0]    span_y;
  logic [FIELD_W:0]    min_ext;
  trht_region_t        new_entry;
  logic                match;
  logic [31:0]         px;
  logic [31:0]         py;
  logic                can_read;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_page_q <= '0;
      min_size_q <= MIN_W'(5);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CURRENT_PAGE: cur_page_q <= cfg_data_i[CPAGE_W-1:0];
        CFG_MIN_SIZE:     min_size_q <= cfg_data_i[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= item_i;
  end

  // Decode the event kind
  always_comb begin
    do_scan   = 1'b0;
    scan_mode = MODE_CLICK;
    case (item_q.kind)
      KIND_TOUCH: begin
        do_scan = !item_q.pressed;
      end
      KIND_GESTURE: begin
        case (item_q.gesture)
          GEST_DOUBLE: begin
            do_scan   = 1'b1;
            scan_mode = MODE_DOUBLE;
          end
          GEST_LONG: begin
            do_scan   = 1'b1;
            scan_mode = MODE_LONG;
          end
          default: do_scan = 1'b0;
        endcase
      end
      default: do_scan = 1'b0;
    endcase
  end

  // Validate and normalise a new region
  assign span_x  = abs_diff(item_q.x_first, item_q.x_second);
  assign span_y  = abs_diff(item_q.y_first, item_q.y_second);
  assign min_ext = {{(FIELD_W+1-MIN_W){1'b0}}, min_size_q};

  assign define_ok = (item_q.kind == KIND_DEFINE) &&
                     coord_ok(item_q.x_first) && coord_ok(item_q.x_second) &&
                     coord_ok(item_q.y_first) && coord_ok(item_q.y_second) &&
                     (span_x > min_ext) && (span_y > min_ext) &&
                     (item_q.element_id != '0) &&
                     (count_q != CNT_W'(MAX_REGIONS));

  always_comb begin
    if ($signed(item_q.x_first) < $signed(item_q.x_second)) begin
      new_entry.left  = to_coord(item_q.x_first);
      new_entry.right = to_coord(item_q.x_second);
    end else begin
      new_entry.left  = to_coord(item_q.x_second);
      new_entry.right = to_coord(item_q.x_first);
    end
    if ($signed(item_q.y_first) < $signed(item_q.y_second)) begin
      new_entry.lower = to_coord(item_q.y_first);
      new_entry.top   = to_coord(item_q.y_second);
    end else begin
      new_entry.lower = to_coord(item_q.y_second);
      new_entry.top   = to_coord(item_q.y_first);
    end
    new_entry.page = to_page(item_q.region_page);
    new_entry.id   = item_q.element_id;
  end

  // Region table: write at the fill count, read at the scan index
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish_plain && define_ok) mem_q[count_q[IDX_W-1:0]] <= new_entry;
    if (cmd_i.scan_step && can_read) rd_data_q <= mem_q[scan_idx_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.finish_plain && define_ok) begin
      count_q <= count_q + CNT_W'(1);
    end
  end

  // Scan sequencing: issue a read each scan cycle while entries remain, compare in the next cycle
  assign can_read = scan_idx_q < count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      cmp_idx_q  <= '0;
      pend_q     <= 1'b0;
    end else if (cmd_i.scan_start) begin
      scan_idx_q <= '0;
      pend_q     <= 1'b0;
    end else if (cmd_i.scan_step) begin
      pend_q <= can_read;
      if (can_read) begin
        cmp_idx_q  <= scan_idx_q;
        scan_idx_q <= scan_idx_q + CNT_W'(1);
      end
    end
  end

  assign px = {{(32-FIELD_W){1'b0}}, item_q.x_first};
  assign py = {{(32-FIELD_W){1'b0}}, item_q.y_first};

  assign match = pend_q && !item_q.x_first[FIELD_W-1] && !item_q.y_first[FIELD_W-1] &&
                 (rd_data_q.page == to_page(cur_page_q)) &&
                 (px >= 32'(rd_data_q.left))  && (px <= 32'(rd_data_q.right)) &&
                 (py >= 32'(rd_data_q.lower)) && (py <= 32'(rd_data_q.top));

  assign sts_o.do_scan    = do_scan;
  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.scan_hit   = match;
  assign sts_o.scan_end   = pend_q && !match &&
                            ((cmp_idx_q + CNT_W'(1)) == count_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // Result staging
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish_plain) begin
      res_hit_q  <= 1'b0;
      res_id_q   <= '0;
      res_mode_q <= MODE_CLICK;
      res_page_q <= '0;
      res_ok_q   <= define_ok;
    end else if (cmd_i.scan_done) begin
      res_hit_q  <= match;
      res_id_q   <= match ? rd_data_q.id : '0;
      res_mode_q <= match ? scan_mode : MODE_CLICK;
      res_page_q <= match ? cur_page_q : '0;
      res_ok_q   <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_hit_q  <= res_hit_q;
      out_id_q   <= res_id_q;
      out_mode_q <= res_mode_q;
      out_page_q <= res_page_q;
      out_ok_q   <= res_ok_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = out_hit_q;
  assign hit_id_o     = out_id_q;
  assign touch_mode_o = out_mode_q;
  assign hit_page_o   = out_page_q;
  assign define_ok_o  = out_ok_q;

endmodule
